// ===== sv/gvoe_pkg.sv =====
// Shared constants, entry codes and types for the guarded variable operation engine.
// Used by gvoe_serial_alu and guarded_variable_op_engine_core; depends on nothing.
`default_nettype none

package gvoe_pkg;

	// Store geometry.
	localparam int unsigned NUM_VARS = 64;
	localparam int unsigned ADDR_W   = $clog2(NUM_VARS);
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STEP_W   = $clog2(DATA_W);

	// Entry commands.
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_COND  = 3'd1;
	localparam logic [2:0] CMD_OP    = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_WRITE = 3'd4;

	// Relations of a condition entry; other codes are always true.
	localparam logic [2:0] REL_LT = 3'd1;
	localparam logic [2:0] REL_LE = 3'd2;
	localparam logic [2:0] REL_EQ = 3'd3;
	localparam logic [2:0] REL_GE = 3'd4;
	localparam logic [2:0] REL_GT = 3'd5;
	localparam logic [2:0] REL_NE = 3'd6;

	// Ways to fold a condition into the verdict.
	localparam logic [1:0] COMB_AND     = 2'd0;
	localparam logic [1:0] COMB_OR      = 2'd1;
	localparam logic [1:0] COMB_XOR     = 2'd2;
	localparam logic [1:0] COMB_REPLACE = 2'd3;

	// Operation types; other codes keep the value.
	localparam logic [2:0] OP_SET = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;

	// Functions of the serial arithmetic unit.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// Completion and compare flags from the arithmetic unit.
	typedef struct packed {
		logic done;
		logic lt;
		logic eq;
	} alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/gvoe_serial_alu.sv =====
// Serial arithmetic unit: bit-serial add, subtract and compare, shift-add multiply
// and restoring divide, one step per cycle. Depends on gvoe_pkg.
`default_nettype none

module gvoe_serial_alu (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gvoe_pkg::alu_req_t            req,
	input  wire logic [gvoe_pkg::DATA_W-1:0]   a,
	input  wire logic [gvoe_pkg::DATA_W-1:0]   b,
	output gvoe_pkg::alu_rsp_t                 rsp,
	output logic [gvoe_pkg::DATA_W-1:0]        result
);

	localparam int unsigned W = gvoe_pkg::DATA_W;

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIN
	} alu_state_t;

	alu_state_t                     state_q;
	gvoe_pkg::alu_op_t              op_q;
	logic [gvoe_pkg::STEP_W-1:0]    cnt_q;
	logic [W-1:0]                   x_q;
	logic [W-1:0]                   y_q;
	logic [W-1:0]                   r_q;
	logic                           c_q;
	logic                           v_q;
	logic                           nz_q;
	logic                           neg_q;
	logic                           done_q;
	logic                           lt_q;
	logic                           eq_q;
	logic [W-1:0]                   result_q;

	logic                           sum_bit;
	logic                           carry_out;
	logic [W:0]                     div_trial;
	logic [W:0]                     div_diff;
	logic                           last_step;

	// One full-adder slice for the serial add and subtract, and one trial
	// subtraction for the restoring divide.
	always_comb begin
		sum_bit   = x_q[0] ^ y_q[0] ^ c_q;
		carry_out = (x_q[0] & y_q[0]) | (x_q[0] & c_q) | (y_q[0] & c_q);
		div_trial = {r_q, x_q[W-1]};
		div_diff  = div_trial - {1'b0, y_q};
		last_step = (cnt_q == gvoe_pkg::STEP_W'(W - 1));
	end

	// Sequencer of the unit and its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == A_FIN);
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						cnt_q <= '0;
						r_q   <= '0;
						nz_q  <= 1'b0;
						v_q   <= 1'b0;
						neg_q <= a[W-1] ^ b[W-1];
						unique case (req.op)
							gvoe_pkg::ALU_ADD: begin
								x_q <= a;
								y_q <= b;
								c_q <= 1'b0;
							end
							gvoe_pkg::ALU_SUB: begin
								x_q <= a;
								y_q <= ~b;
								c_q <= 1'b1;
							end
							gvoe_pkg::ALU_MUL: begin
								x_q <= a;
								y_q <= b;
								c_q <= 1'b0;
							end
							gvoe_pkg::ALU_DIV: begin
								x_q <= a[W-1] ? (W'(0) - a) : a;
								y_q <= b[W-1] ? (W'(0) - b) : b;
								c_q <= 1'b0;
							end
							default: begin
								x_q <= a;
								y_q <= b;
								c_q <= 1'b0;
							end
						endcase
						state_q <= A_RUN;
					end
				end
				A_RUN: begin
					unique case (op_q)
						gvoe_pkg::ALU_ADD, gvoe_pkg::ALU_SUB: begin
							r_q  <= {sum_bit, r_q[W-1:1]};
							x_q  <= {1'b0, x_q[W-1:1]};
							y_q  <= {1'b0, y_q[W-1:1]};
							c_q  <= carry_out;
							nz_q <= nz_q | sum_bit;
							if (last_step) begin
								v_q <= c_q ^ carry_out;
							end
						end
						gvoe_pkg::ALU_MUL: begin
							if (y_q[0]) begin
								r_q <= r_q + x_q;
							end
							x_q <= {x_q[W-2:0], 1'b0};
							y_q <= {1'b0, y_q[W-1:1]};
						end
						gvoe_pkg::ALU_DIV: begin
							if (!div_diff[W]) begin
								r_q <= div_diff[W-1:0];
							end else begin
								r_q <= div_trial[W-1:0];
							end
							x_q <= {x_q[W-2:0], ~div_diff[W]};
						end
						default: begin
							r_q <= r_q;
						end
					endcase
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					lt_q   <= r_q[W-1] ^ v_q;
					eq_q   <= ~nz_q;
					if (op_q == gvoe_pkg::ALU_DIV) begin
						result_q <= neg_q ? (W'(0) - x_q) : x_q;
					end else begin
						result_q <= r_q;
					end
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.lt   = lt_q;
	assign rsp.eq   = eq_q;
	assign result   = result_q;

`ifndef SYNTHESIS
	// A request is only taken while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == A_IDLE)
		else $error("arithmetic request while unit busy");

	// Completion follows in the cycle after the finishing step.
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_FIN |=> done_q && state_q == A_IDLE)
		else $error("arithmetic completion lost");

	// The unit stays idle until it gets a request.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_IDLE && !req.start |=> state_q == A_IDLE)
		else $error("arithmetic unit started without a request");
`endif

endmodule

`default_nettype wire

// ===== sv/guarded_variable_op_engine_core.sv =====
// Top level of the guarded variable operation engine: entry sequencer, variable store
// and output register. Depends on gvoe_pkg and gvoe_serial_alu.
`default_nettype none

// The engine keeps 64 signed 32-bit variables, all zero after reset (per-entry valid
// bits cleared by reset, so no clearing pass is needed), and a running verdict that
// starts at one. It takes one entry at a time and returns one result item per entry.
// Start-group, read, write, set and skipped or keep operations pass through store read,
// decide and write-back, where the result enters the output register once it is free.
// Conditions and add, subtract, multiply and divide go through a bit-serial arithmetic
// unit between decide and write-back; that unit steps 32 times and sets their rate.
// A division by zero skips the unit and reports div_by_zero. The next entry is accepted
// as soon as the previous one is written back, even while its result still waits in the
// output register.
module guarded_variable_op_engine_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           cmd,
	input  wire logic [5:0]           var_index,
	input  wire logic [2:0]           compare_op,
	input  wire logic [1:0]           combine_op,
	input  wire logic [2:0]           op_type,
	input  wire logic signed [31:0]   operand_value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      verdict,
	output logic signed [31:0]        var_value,
	output logic                      performed,
	output logic                      div_by_zero
);

	localparam int unsigned W  = gvoe_pkg::DATA_W;
	localparam int unsigned AW = gvoe_pkg::ADDR_W;
	localparam int unsigned NV = gvoe_pkg::NUM_VARS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_WB
	} seq_state_t;

	seq_state_t          state_q;
	logic                verdict_q;

	// Entry fields held for the whole item.
	logic [2:0]          cmd_q;
	logic [2:0]          cmp_q;
	logic [1:0]          comb_q;
	logic [2:0]          op_q;
	logic [W-1:0]        val_q;
	logic [AW-1:0]       addr_q;
	logic                inr_q;

	// Store read data and per-entry valid bits.
	logic [W-1:0]        mem [NV];
	logic [NV-1:0]       vld_q;
	logic [W-1:0]        rdata_q;
	logic                rvld_q;

	// Item results before the output register.
	logic [W-1:0]        nv_q;
	logic                we_q;
	logic                perf_q;
	logic                dz_q;

	// Output register.
	logic                out_valid_q;
	logic                out_verdict_q;
	logic [W-1:0]        out_value_q;
	logic                out_perf_q;
	logic                out_dz_q;

	logic                accept;
	logic [AW-1:0]       in_addr;
	logic                in_range;
	logic [W-1:0]        cur_value;
	logic                out_free;
	logic                mem_we;
	logic                exec_op;
	logic                take_operand;
	logic                cond_hit;
	logic                cond_verdict;
	gvoe_pkg::alu_req_t  alu_req;
	gvoe_pkg::alu_rsp_t  alu_rsp;
	logic [W-1:0]        alu_result;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_addr   = AW'(var_index);
	assign in_range  = (32'(var_index) < NV);
	assign cur_value = rvld_q ? rdata_q : '0;
	assign out_free  = !out_valid_q || !out_stall;
	assign mem_we    = (state_q == S_WB) && out_free && we_q && inr_q;

	// An operation entry is carried out only under a set verdict; a write entry
	// or a set operation takes the operand as the new value.
	assign exec_op      = (cmd_q == gvoe_pkg::CMD_OP) && verdict_q;
	assign take_operand = (cmd_q == gvoe_pkg::CMD_WRITE) ||
		(exec_op && (op_q == gvoe_pkg::OP_SET));

	// Variable store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= nv_q;
		end
		if (accept) begin
			rdata_q <= mem[in_addr];
		end
	end

	// Valid bits: an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (accept) begin
				rvld_q <= in_range && vld_q[in_addr];
			end
		end
	end

	// Arithmetic requests issued in the decide cycle.
	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = gvoe_pkg::ALU_ADD;
		if (state_q == S_EXEC) begin
			if (cmd_q == gvoe_pkg::CMD_COND) begin
				alu_req.start = 1'b1;
				alu_req.op    = gvoe_pkg::ALU_SUB;
			end else if (cmd_q == gvoe_pkg::CMD_OP && verdict_q) begin
				unique case (op_q)
					gvoe_pkg::OP_ADD: begin
						alu_req.start = 1'b1;
						alu_req.op    = gvoe_pkg::ALU_ADD;
					end
					gvoe_pkg::OP_SUB: begin
						alu_req.start = 1'b1;
						alu_req.op    = gvoe_pkg::ALU_SUB;
					end
					gvoe_pkg::OP_MUL: begin
						alu_req.start = 1'b1;
						alu_req.op    = gvoe_pkg::ALU_MUL;
					end
					gvoe_pkg::OP_DIV: begin
						alu_req.start = (val_q != '0);
						alu_req.op    = gvoe_pkg::ALU_DIV;
					end
					default: begin
						alu_req.start = 1'b0;
					end
				endcase
			end
		end
	end

	gvoe_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (cur_value),
		.b      (val_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	// Relation of the condition entry and its fold into the verdict.
	always_comb begin
		unique case (cmp_q)
			gvoe_pkg::REL_LT: cond_hit = alu_rsp.lt;
			gvoe_pkg::REL_LE: cond_hit = alu_rsp.lt | alu_rsp.eq;
			gvoe_pkg::REL_EQ: cond_hit = alu_rsp.eq;
			gvoe_pkg::REL_GE: cond_hit = ~alu_rsp.lt;
			gvoe_pkg::REL_GT: cond_hit = ~alu_rsp.lt & ~alu_rsp.eq;
			gvoe_pkg::REL_NE: cond_hit = ~alu_rsp.eq;
			default:          cond_hit = 1'b1;
		endcase
		unique case (comb_q)
			gvoe_pkg::COMB_AND:     cond_verdict = cond_hit & verdict_q;
			gvoe_pkg::COMB_OR:      cond_verdict = cond_hit | verdict_q;
			gvoe_pkg::COMB_XOR:     cond_verdict = cond_hit ^ verdict_q;
			gvoe_pkg::COMB_REPLACE: cond_verdict = cond_hit;
			default:                cond_verdict = cond_hit;
		endcase
	end

	// Entry sequencer, verdict and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			verdict_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_WB) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd;
						cmp_q   <= compare_op;
						comb_q  <= combine_op;
						op_q    <= op_type;
						val_q   <= operand_value;
						addr_q  <= in_addr;
						inr_q   <= in_range;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					nv_q    <= take_operand ? val_q : cur_value;
					we_q    <= (cmd_q == gvoe_pkg::CMD_WRITE) || exec_op;
					perf_q  <= exec_op;
					dz_q    <= exec_op && (op_q == gvoe_pkg::OP_DIV) && (val_q == '0);
					if (cmd_q == gvoe_pkg::CMD_START) begin
						verdict_q <= 1'b1;
					end
					state_q <= alu_req.start ? S_WAIT : S_WB;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						if (cmd_q == gvoe_pkg::CMD_COND) begin
							verdict_q <= cond_verdict;
						end else begin
							nv_q <= alu_result;
						end
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_verdict_q <= verdict_q;
						out_value_q   <= inr_q ? nv_q : '0;
						out_perf_q    <= perf_q;
						out_dz_q      <= dz_q;
						state_q       <= S_IDLE;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = out_verdict_q;
	assign var_value   = out_value_q;
	assign performed   = out_perf_q;
	assign div_by_zero = out_dz_q;

`ifndef SYNTHESIS
	// The arithmetic unit only finishes while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_WAIT)
		else $error("arithmetic completion outside wait state");

	// A zero divisor is only reported for an operation that was carried out.
	a_dz_perf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> performed)
		else $error("division by zero reported without operation");

	// A new result only appears after the write-back step.
	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WB))
		else $error("result issued outside write-back");

	// The store is never written while an item is still being decided.
	a_we_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> state_q == S_IDLE)
		else $error("store write did not complete the item");
`endif

endmodule

`default_nettype wire

// ===== tb/guarded_variable_op_engine_core_tb.sv =====
// Self-checking testbench for guarded_variable_op_engine_core: directed and random entries.
// Depends on gvoe_pkg and the engine RTL; predicts every result with its own variable store model.
`timescale 1ns / 1ps

module guarded_variable_op_engine_core_tb;

	// Codes without a name in the package.
	localparam logic [2:0] CMD_SPARE      = 3'd5;
	localparam logic [2:0] REL_ALWAYS     = 3'd0;
	localparam logic [2:0] REL_ALWAYS_TOP = 3'd7;
	localparam logic [2:0] OP_KEEP        = 3'd5;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_CYCLES    = 300;

	// One script entry as driven on the input ports.
	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  idx;
		logic [2:0]  rel;
		logic [1:0]  comb;
		logic [2:0]  op;
		logic [31:0] operand;
	} entry_t;

	// One result item as seen on the output ports.
	typedef struct packed {
		logic        verdict;
		logic [31:0] value;
		logic        performed;
		logic        dz;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [2:0]          cmd;
	logic [5:0]          var_index;
	logic [2:0]          compare_op;
	logic [1:0]          combine_op;
	logic [2:0]          op_type;
	logic signed [31:0]  operand_value;
	logic                out_valid;
	logic                out_stall;
	logic                verdict;
	logic signed [31:0]  var_value;
	logic                performed;
	logic                div_by_zero;

	// Shadow copy of the engine state.
	logic [31:0] shadow_vars [0:gvoe_pkg::NUM_VARS-1];
	logic        shadow_verdict;

	result_t pending_results [$];

	bit send_idle;
	bit recv_idle;
	int hold_request;
	int entries_sent;
	int results_seen;
	int ops_performed;
	int zero_divisors;
	int mismatches;
	int quiet_cycles;

	guarded_variable_op_engine_core dut (.*);

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic entry_t make_entry(logic [2:0] c, logic [5:0] i, logic [2:0] rl,
			logic [1:0] cb, logic [2:0] o, logic [31:0] v);
		entry_t e;
		e.cmd = c;
		e.idx = i;
		e.rel = rl;
		e.comb = cb;
		e.op = o;
		e.operand = v;
		return e;
	endfunction

	// Applies one entry to the shadow state and returns the result it should produce.
	function automatic result_t apply_entry(entry_t e);
		result_t r;
		logic [31:0] cur;
		logic [31:0] mag_n;
		logic [31:0] mag_d;
		logic [31:0] quo;
		logic hit;
		r = '0;
		cur = shadow_vars[e.idx];
		hit = 1'b1;
		case (e.cmd)
			gvoe_pkg::CMD_START: begin
				shadow_verdict = 1'b1;
			end
			gvoe_pkg::CMD_COND: begin
				case (e.rel)
					gvoe_pkg::REL_LT: hit = $signed(cur) <  $signed(e.operand);
					gvoe_pkg::REL_LE: hit = $signed(cur) <= $signed(e.operand);
					gvoe_pkg::REL_EQ: hit = cur == e.operand;
					gvoe_pkg::REL_GE: hit = $signed(cur) >= $signed(e.operand);
					gvoe_pkg::REL_GT: hit = $signed(cur) >  $signed(e.operand);
					gvoe_pkg::REL_NE: hit = cur != e.operand;
					default: hit = 1'b1;
				endcase
				case (e.comb)
					gvoe_pkg::COMB_AND: shadow_verdict = hit & shadow_verdict;
					gvoe_pkg::COMB_OR:  shadow_verdict = hit | shadow_verdict;
					gvoe_pkg::COMB_XOR: shadow_verdict = hit ^ shadow_verdict;
					default:  shadow_verdict = hit;
				endcase
			end
			gvoe_pkg::CMD_OP: begin
				if (shadow_verdict) begin
					r.performed = 1'b1;
					case (e.op)
						gvoe_pkg::OP_SET: cur = e.operand;
						gvoe_pkg::OP_ADD: cur = cur + e.operand;
						gvoe_pkg::OP_SUB: cur = cur - e.operand;
						gvoe_pkg::OP_MUL: cur = cur * e.operand;
						gvoe_pkg::OP_DIV: begin
							if (e.operand == '0) begin
								r.dz = 1'b1;
							end else begin
								// Divide magnitudes, then restore the sign; truncates toward zero.
								mag_n = cur[31] ? -cur : cur;
								mag_d = e.operand[31] ? -e.operand : e.operand;
								quo = mag_n / mag_d;
								cur = (cur[31] ^ e.operand[31]) ? -quo : quo;
							end
						end
						default: ;
					endcase
					shadow_vars[e.idx] = cur;
				end
			end
			gvoe_pkg::CMD_WRITE: begin
				shadow_vars[e.idx] = e.operand;
			end
			default: ;
		endcase
		r.verdict = shadow_verdict;
		r.value = shadow_vars[e.idx];
		return r;
	endfunction

	// Offers one item after a random gap and records its expected result once accepted.
	task automatic send_entry(input entry_t e);
		int gap;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = e.cmd;
		var_index = e.idx;
		compare_op = e.rel;
		combine_op = e.comb;
		op_type = e.op;
		operand_value = e.operand;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_entry(e));
		entries_sent++;
		@(negedge clk);
	endtask

	// Mostly a small working set of variables, so entries interact.
	function automatic logic [5:0] pick_index();
		return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
	endfunction

	// Operands near the extremes, near zero, near the variable's current value or fully random.
	function automatic logic [31:0] pick_operand(logic [5:0] idx);
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'($urandom_range(0, 16)) - 32'd8;
			4, 5: return shadow_vars[idx] + 32'($urandom_range(0, 2)) - 32'd1;
			default: return $urandom;
		endcase
	endfunction

	// Extremes, every relation, fold and operation, and the special cases.
	task automatic test_directed();
		send_entry(make_entry(gvoe_pkg::CMD_WRITE, 6'd0, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h7fff_ffff));
		send_entry(make_entry(gvoe_pkg::CMD_WRITE, 6'd1, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h8000_0000));
		send_entry(make_entry(gvoe_pkg::CMD_READ, 6'd0, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h0));
		// Add and subtract wrap around.
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd0, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_ADD, 32'd1));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd1, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SUB, 32'd1));
		send_entry(make_entry(gvoe_pkg::CMD_WRITE, 6'd2, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h0001_0003));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd2, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_MUL, 32'hffff_0007));
		// Most negative value divided by minus one, then by zero.
		send_entry(make_entry(gvoe_pkg::CMD_WRITE, 6'd3, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h8000_0000));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd3, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_DIV, 32'hffff_ffff));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd3, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_DIV, 32'h0));
		send_entry(make_entry(gvoe_pkg::CMD_WRITE, 6'd4, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, -32'sd7));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd4, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_DIV, 32'd2));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd5, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'd123));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd5, REL_ALWAYS, gvoe_pkg::COMB_AND,
			OP_KEEP, 32'd99));
		// Each relation once, with every fold in use; the verdict drops to zero midway.
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_LT,
			gvoe_pkg::COMB_REPLACE, gvoe_pkg::OP_SET, 32'd200));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_LE,
			gvoe_pkg::COMB_AND, gvoe_pkg::OP_SET, 32'd123));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_EQ,
			gvoe_pkg::COMB_AND, gvoe_pkg::OP_SET, 32'd123));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_GE,
			gvoe_pkg::COMB_AND, gvoe_pkg::OP_SET, 32'd124));
		send_entry(make_entry(gvoe_pkg::CMD_OP, 6'd5, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_ADD, 32'd1));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_GT,
			gvoe_pkg::COMB_OR, gvoe_pkg::OP_SET, 32'h8000_0000));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_NE,
			gvoe_pkg::COMB_XOR, gvoe_pkg::OP_SET, 32'd123));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, REL_ALWAYS, gvoe_pkg::COMB_XOR,
			gvoe_pkg::OP_SET, 32'd0));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, REL_ALWAYS_TOP, gvoe_pkg::COMB_OR,
			gvoe_pkg::OP_SET, 32'd0));
		send_entry(make_entry(gvoe_pkg::CMD_COND, 6'd5, gvoe_pkg::REL_EQ,
			gvoe_pkg::COMB_REPLACE, gvoe_pkg::OP_SET, 32'd999));
		send_entry(make_entry(gvoe_pkg::CMD_START, 6'd63, REL_ALWAYS, gvoe_pkg::COMB_AND,
			gvoe_pkg::OP_SET, 32'h0));
		// Unused commands change nothing.
		for (int k = 0; k < 3; k++) begin
			send_entry(make_entry(CMD_SPARE + 3'(k), 6'd63, REL_ALWAYS, gvoe_pkg::COMB_AND,
				gvoe_pkg::OP_SET, 32'hffff_ffff));
		end
	endtask

	// Well-formed groups: start, conditions, guarded operations, with some direct access.
	task automatic test_guarded_scripts(input int groups);
		logic [5:0] idx;
		logic [2:0] op;
		for (int g = 0; g < groups; g++) begin
			// Every fourth stretch of groups runs with no idling on either side.
			send_idle = (g % 20) >= 5;
			recv_idle = (g % 20) >= 5;
			if ($urandom_range(0, 9) != 0) begin
				send_entry(make_entry(gvoe_pkg::CMD_START, pick_index(), 3'($urandom),
					2'($urandom), 3'($urandom), $urandom));
			end
			repeat ($urandom_range(0, 3)) begin
				idx = pick_index();
				send_entry(make_entry(gvoe_pkg::CMD_COND, idx, 3'($urandom), 2'($urandom),
					3'($urandom), pick_operand(idx)));
			end
			repeat ($urandom_range(1, 3)) begin
				idx = pick_index();
				op = ($urandom_range(0, 9) > 7) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				send_entry(make_entry(gvoe_pkg::CMD_OP, idx, 3'($urandom), 2'($urandom), op,
					pick_operand(idx)));
			end
			if ($urandom_range(0, 3) == 0) begin
				idx = pick_index();
				send_entry(make_entry(($urandom_range(0, 1) == 0) ? gvoe_pkg::CMD_READ
					: gvoe_pkg::CMD_WRITE, idx, 3'($urandom), 2'($urandom), 3'($urandom),
					pick_operand(idx)));
			end
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// The result side holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		logic [5:0] idx;
		send_idle = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (12) begin
			idx = pick_index();
			send_entry(make_entry(3'($urandom_range(0, 4)), idx, 3'($urandom), 2'($urandom),
				3'($urandom_range(0, 4)), pick_operand(idx)));
		end
		send_idle = 1'b1;
	endtask

	// Fully random fields, unused codes included.
	task automatic test_random_noise(input int count);
		repeat (count) begin
			send_entry(make_entry(3'($urandom), 6'($urandom), 3'($urandom), 2'($urandom),
				3'($urandom), $urandom));
		end
	endtask

	// Result side: draws a stall for each item, plus one long hold when asked.
	initial begin : result_sink
		int gap;
		out_stall = 1'b0;
		forever begin
			if (hold_request > 0) begin
				out_stall = 1'b1;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			gap = recv_idle ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: verdict %0d value %0d",
						$realtime, verdict, var_value);
			end else begin
				want = pending_results.pop_front();
				ops_performed += want.performed;
				zero_divisors += want.dz;
				if (verdict !== want.verdict || var_value !== want.value ||
						performed !== want.performed || div_by_zero !== want.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch: expected v=%0d val=%0d p=%0d dz=%0d, ",
							"got v=%0d val=%0d p=%0d dz=%0d"},
							$realtime, want.verdict, $signed(want.value), want.performed, want.dz,
							verdict, var_value, performed, div_by_zero);
				end
			end
		end
	end

	// Ends the run if no item moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles, %0d results outstanding.",
				quiet_cycles, pending_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = gvoe_pkg::CMD_START;
		var_index = '0;
		compare_op = REL_ALWAYS;
		combine_op = gvoe_pkg::COMB_AND;
		op_type = gvoe_pkg::OP_SET;
		operand_value = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_request = 0;
		entries_sent = 0;
		results_seen = 0;
		ops_performed = 0;
		zero_divisors = 0;
		mismatches = 0;
		quiet_cycles = 0;
		for (int i = 0; i < gvoe_pkg::NUM_VARS; i++)
			shadow_vars[i] = '0;
		shadow_verdict = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_guarded_scripts(80);
		test_backpressure();
		test_random_noise(60);
		in_valid = 1'b0;

		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d script entries and checked %0d results, including %0d guarded",
			entries_sent, results_seen, ops_performed);
		$display("operations and %0d zero divisors; %0d mismatches.", zero_divisors, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
